[design/apcr_pkg.sv]
// Package for the calibrated analog probe reading core.
// Holds the register map, the configuration and stage payload types, and the
// fixed-point constants of the compensation datapath. No dependencies.
package apcr_pkg;

    // Field widths
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned RAW_W   = 12;
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned Q16_W   = 32;

    // Compensation datapath widths
    localparam int unsigned DT_W    = TEMP_W + 1;          // temperature difference
    localparam int unsigned M_W     = DT_W + COEF_W + 1;   // dt * coefficient
    localparam int unsigned U_W     = 30;                  // offset product, unsigned
    localparam int unsigned QE_W    = 22;                  // quotient estimate
    localparam int unsigned QSH     = 30;                  // reciprocal shift, quotient
    localparam int unsigned N_W     = U_W + 6;             // u * 64
    localparam int unsigned R0_W    = 15;                  // remainder before correction
    localparam int unsigned R_W     = 14;                  // corrected remainder
    localparam int unsigned QS_W    = 22;                  // signed Q16.16 factor
    localparam int unsigned W_W     = RAW_W + R_W;         // raw * remainder
    localparam int unsigned WSH     = 40;                  // reciprocal shift, fraction
    localparam int unsigned COMP_W  = RAW_W + 1 + QS_W;    // compensated raw, Q16.16
    localparam int unsigned PH_W    = COMP_W + 16;
    localparam int unsigned PL_W    = COMP_W + 17;
    localparam int unsigned SUM_W   = PL_W + 1;

    // 16e6 = 2^10 * 15625, so the compensation divides by 15625 after a shift.
    localparam logic [R_W-1:0]      DIV_D    = 14'd15625;
    localparam logic [22:0]         RECIP_U  = 23'd4398046;     // floor(2^36 / 15625)
    localparam logic [26:0]         RECIP_W  = 27'd70368745;    // ceil(2^40 / 15625)
    // Adding 15625 * 2^15 makes dt * coefficient non-negative; it adds 2^21
    // to the quotient, which is removed together with the unity term 65536.
    localparam logic signed [U_W:0] U_OFFSET = 31'sd512000000;
    localparam logic signed [23:0]  Q_BIAS   = 24'sd2031616;

    localparam logic [Q16_W-1:0]    EV_MAX   = 32'h7FFF_FFFF;
    localparam logic [Q16_W-1:0]    EV_MIN   = 32'h8000_0000;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_CALIB_TEMPERATURE,
        REG_TEMP_COEFFICIENT,
        REG_GAIN,
        REG_BIAS
    } reg_idx_t;

    localparam logic [TEMP_W-1:0] CALIB_RESET = 12'd400;
    localparam logic [COEF_W-1:0] COEF_RESET  = 16'd0;
    localparam logic [Q16_W-1:0]  GAIN_RESET  = 32'd65536;
    localparam logic [Q16_W-1:0]  BIAS_RESET  = 32'd0;

    typedef struct packed {
        logic [TEMP_W-1:0] calib_temperature;
        logic [COEF_W-1:0] temp_coefficient;
        logic [Q16_W-1:0]  gain;
        logic [Q16_W-1:0]  bias;
    } cfg_t;

    // Item handed from the compensation pipeline to the scaling pipeline.
    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [COMP_W-1:0] comp;
    } comp_item_t;

endpackage

[design/apcr_cfg_regs.sv]
// Configuration register file with an APB-style slave port.
// Depends on apcr_pkg for the register map and the configuration type.
module apcr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [apcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [apcr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output apcr_pkg::cfg_t                cfg
);
    import apcr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_CALIB_TEMPERATURE: cfg_next.calib_temperature = pwdata[TEMP_W-1:0];
                REG_TEMP_COEFFICIENT:  cfg_next.temp_coefficient  = pwdata[COEF_W-1:0];
                REG_GAIN:              cfg_next.gain              = pwdata[Q16_W-1:0];
                REG_BIAS:              cfg_next.bias              = pwdata[Q16_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calib_temperature <= CALIB_RESET;
            cfg_reg.temp_coefficient  <= COEF_RESET;
            cfg_reg.gain              <= GAIN_RESET;
            cfg_reg.bias              <= BIAS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_CALIB_TEMPERATURE:
                prdata = {{(PDATA_W-TEMP_W){cfg_reg.calib_temperature[TEMP_W-1]}},
                          cfg_reg.calib_temperature};
            REG_TEMP_COEFFICIENT:
                prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_reg.temp_coefficient};
            REG_GAIN:
                prdata = cfg_reg.gain;
            REG_BIAS:
                prdata = cfg_reg.bias;
            default:
                prdata = '0;
        endcase
    end

endmodule

[design/apcr_comp.sv]
// Seven-stage pipeline that decodes the raw reading and applies the
// temperature compensation, giving the compensated value in Q16.16.
// Depends on apcr_pkg for widths, constants and the output item type.
module apcr_comp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apcr_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    raw_high_byte,
    input  logic [7:0]                    raw_low_byte,
    input  logic [apcr_pkg::TEMP_W-1:0]   temperature,
    output logic                          out_valid,
    input  logic                          out_ready,
    output apcr_pkg::comp_item_t          out_item
);
    import apcr_pkg::*;

    localparam int unsigned NS = 7;

    logic [NS:1]   vld_reg;
    logic [NS:1]   vld_next;
    logic [NS+1:1] adv;

    logic [RAW_W-1:0] raw_reg [1:NS];
    logic [RAW_W-1:0] raw_next;

    logic signed [DT_W-1:0]   s1_dt_reg, s1_dt_next;
    logic [U_W-1:0]           s2_u_reg, s2_u_next;
    logic [U_W-1:0]           s3_u_reg;
    logic [QE_W-1:0]          s3_qe_reg, s3_qe_next;
    logic [QE_W-1:0]          s4_qe_reg;
    logic [R0_W-1:0]          s4_r0_reg, s4_r0_next;
    logic signed [QS_W-1:0]   s5_qs_reg, s5_qs_next;
    logic [W_W-1:0]           s5_w_reg, s5_w_next;
    logic signed [COMP_W-1:0] s6_p1_reg, s6_p1_next;
    logic [RAW_W-1:0]         s6_q2_reg, s6_q2_next;
    logic signed [COMP_W-1:0] s7_comp_reg, s7_comp_next;

    // Combinational intermediates
    logic [7:0]               hb;
    logic [3:0]               lb;
    logic signed [M_W-1:0]    m;
    logic signed [U_W:0]      u_sum;
    logic [U_W+22:0]          pu;
    logic [N_W-1:0]           t;
    logic [N_W-1:0]           rdiff;
    logic [QE_W-1:0]          q;
    logic [R_W-1:0]           r;
    logic signed [23:0]       qsum;
    logic [W_W+26:0]          pw;

    // Handshake: a stage moves on when it is empty or the next one moves.
    always_comb
    begin
        adv[NS+1] = out_ready;
        for (int i = NS; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: invert and bit-reverse the bytes, form the temperature difference.
    always_comb
    begin
        hb = ~raw_high_byte;
        lb = ~raw_low_byte[3:0];
        for (int i = 0; i < 8; i++)
        begin
            raw_next[RAW_W-1-i] = hb[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            raw_next[3-i] = lb[i];
        end
        s1_dt_next = {temperature[TEMP_W-1], temperature}
                   - {cfg.calib_temperature[TEMP_W-1], cfg.calib_temperature};
    end

    // Stage 2: dt * coefficient, moved into the non-negative range.
    always_comb
    begin
        m         = s1_dt_reg * $signed({1'b0, cfg.temp_coefficient});
        u_sum     = {m[M_W-1], m} + U_OFFSET;
        s2_u_next = u_sum[U_W-1:0];
    end

    // Stage 3: quotient estimate of 64u / 15625, low by at most one.
    always_comb
    begin
        pu         = s2_u_reg * RECIP_U;
        s3_qe_next = pu[QE_W+QSH-1:QSH];
    end

    // Stage 4: remainder of the estimate.
    always_comb
    begin
        t          = s3_qe_reg * DIV_D;
        rdiff      = {s3_u_reg, 6'b0} - t;
        s4_r0_next = rdiff[R0_W-1:0];
    end

    // Stage 5: correct the quotient, form the Q16.16 factor and raw * remainder.
    always_comb
    begin
        if (s4_r0_reg >= {1'b0, DIV_D})
        begin
            q = s4_qe_reg + 1'b1;
            r = R_W'(s4_r0_reg - {1'b0, DIV_D});
        end
        else
        begin
            q = s4_qe_reg;
            r = s4_r0_reg[R_W-1:0];
        end
        qsum       = $signed({2'b00, q}) - Q_BIAS;
        s5_qs_next = qsum[QS_W-1:0];
        s5_w_next  = raw_reg[4] * r;
    end

    // Stage 6: integer part of the product and the floored fractional carry.
    always_comb
    begin
        s6_p1_next = $signed({1'b0, raw_reg[5]}) * s5_qs_reg;
        pw         = s5_w_reg * RECIP_W;
        s6_q2_next = pw[RAW_W+WSH-1:WSH];
    end

    // Stage 7: compensated value.
    always_comb
    begin
        s7_comp_next = s6_p1_reg + $signed({{(COMP_W-RAW_W){1'b0}}, s6_q2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            raw_reg[1] <= raw_next;
            s1_dt_reg  <= s1_dt_next;
        end
        if (adv[2])
        begin
            s2_u_reg <= s2_u_next;
        end
        if (adv[3])
        begin
            s3_u_reg  <= s2_u_reg;
            s3_qe_reg <= s3_qe_next;
        end
        if (adv[4])
        begin
            s4_qe_reg <= s3_qe_reg;
            s4_r0_reg <= s4_r0_next;
        end
        if (adv[5])
        begin
            s5_qs_reg <= s5_qs_next;
            s5_w_reg  <= s5_w_next;
        end
        if (adv[6])
        begin
            s6_p1_reg <= s6_p1_next;
            s6_q2_reg <= s6_q2_next;
        end
        if (adv[7])
        begin
            s7_comp_reg <= s7_comp_next;
        end
        for (int i = 2; i <= NS; i++)
        begin
            if (adv[i])
            begin
                raw_reg[i] <= raw_reg[i-1];
            end
        end
    end

    assign out_item.raw  = raw_reg[NS];
    assign out_item.comp = s7_comp_reg;

endmodule

[design/apcr_scale.sv]
// Three-stage pipeline that applies gain and bias to the compensated value
// and saturates the result to 32 bits. Depends on apcr_pkg.
module apcr_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  apcr_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  apcr_pkg::comp_item_t          in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [apcr_pkg::RAW_W-1:0]    raw_value,
    output logic [apcr_pkg::Q16_W-1:0]    eng_value,
    output logic                          saturated
);
    import apcr_pkg::*;

    localparam int unsigned NS = 3;

    logic [NS:1]   vld_reg;
    logic [NS:1]   vld_next;
    logic [NS+1:1] adv;

    logic [RAW_W-1:0] raw_reg [1:NS];

    logic signed [PH_W-1:0]  s1_ph_reg, s1_ph_next;
    logic signed [PL_W-1:0]  s1_pl_reg, s1_pl_next;
    logic signed [SUM_W-1:0] s2_sum_reg, s2_sum_next;
    logic [Q16_W-1:0]        s3_eng_reg, s3_eng_next;
    logic                    s3_sat_reg, s3_sat_next;

    logic signed [COMP_W-1:0] comp;
    logic [SUM_W-Q16_W:0]     top_bits;

    always_comb
    begin
        adv[NS+1] = out_ready;
        for (int i = NS; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: the gain is split into its signed integer and unsigned fraction halves.
    always_comb
    begin
        comp       = $signed(in_item.comp);
        s1_ph_next = comp * $signed(cfg.gain[Q16_W-1:16]);
        s1_pl_next = comp * $signed({1'b0, cfg.gain[15:0]});
    end

    // Stage 2: the arithmetic shift floors the fraction product.
    always_comb
    begin
        s2_sum_next = {{(SUM_W-PH_W){s1_ph_reg[PH_W-1]}}, s1_ph_reg}
                    + {{(SUM_W-PL_W+16){s1_pl_reg[PL_W-1]}}, s1_pl_reg[PL_W-1:16]}
                    + {{(SUM_W-Q16_W){cfg.bias[Q16_W-1]}}, cfg.bias};
    end

    // Stage 3: the value fits when all bits from bit 31 upward agree.
    always_comb
    begin
        top_bits = s2_sum_reg[SUM_W-1:Q16_W-1];
        if ((top_bits == '0) || (top_bits == '1))
        begin
            s3_eng_next = s2_sum_reg[Q16_W-1:0];
            s3_sat_next = 1'b0;
        end
        else
        begin
            s3_eng_next = s2_sum_reg[SUM_W-1] ? EV_MIN : EV_MAX;
            s3_sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            raw_reg[1] <= in_item.raw;
            s1_ph_reg  <= s1_ph_next;
            s1_pl_reg  <= s1_pl_next;
        end
        if (adv[2])
        begin
            raw_reg[2] <= raw_reg[1];
            s2_sum_reg <= s2_sum_next;
        end
        if (adv[3])
        begin
            raw_reg[3] <= raw_reg[2];
            s3_eng_reg <= s3_eng_next;
            s3_sat_reg <= s3_sat_next;
        end
    end

    assign raw_value = raw_reg[NS];
    assign eng_value = s3_eng_reg;
    assign saturated = s3_sat_reg;

endmodule

[design/analog_probe_calibrated_reading_core.sv]
// Calibrated analog probe reading: ten-stage pipeline, one transfer per cycle while the output is not stalled.
// A result passes through the compensation pipeline and then the scaling pipeline before its result transfer.
// Throughput is one item per cycle; a stage only holds when its successor holds, so bubbles close up.
// Multipliers are at most 35 x 17, 30 x 23 or 26 x 27 bits; the widest add is a three-input 53-bit sum.
// Reset clears all valid bits and loads the register reset values; no clearing pass follows.
module analog_probe_calibrated_reading_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [apcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [apcr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    raw_high_byte,
    input  logic [7:0]                    raw_low_byte,
    input  logic signed [apcr_pkg::TEMP_W-1:0] temperature,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [apcr_pkg::RAW_W-1:0]    raw_value,
    output logic signed [apcr_pkg::Q16_W-1:0] eng_value,
    output logic                          saturated
);
    import apcr_pkg::*;

    cfg_t       cfg;
    comp_item_t mid_item;
    logic       mid_valid;
    logic       mid_ready;
    logic       comp_in_ready;
    logic [Q16_W-1:0] eng_bits;

    apcr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apcr_comp u_comp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (comp_in_ready),
        .raw_high_byte (raw_high_byte),
        .raw_low_byte  (raw_low_byte),
        .temperature   (temperature),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_item      (mid_item)
    );

    apcr_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .raw_value (raw_value),
        .eng_value (eng_bits),
        .saturated (saturated)
    );

    assign in_stall  = !comp_in_ready;
    assign eng_value = $signed(eng_bits);

    // The input can only be held off when every stage is full behind a stalled result.
    a_stall_needs_full_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled while the output transfer is not blocked");

    // A clipped result carries one of the two range limits.
    a_sat_at_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (eng_bits == EV_MAX || eng_bits == EV_MIN)
    ) else $error("saturated result is not at a range limit");

endmodule

[dv/tb.sv]
// Testbench for analog_probe_calibrated_reading_core: directed and random probe readings
// under many register settings, each result checked against an in-line predictor.
// Depends on apcr_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apcr_pkg::*;

    localparam int           WATCHDOG_LIMIT = 2000;
    localparam int           DRAIN_CYCLES   = 20;
    localparam int           RANDOM_PHASES  = 12;
    localparam int           PHASE_READINGS = 112;
    localparam longint       COMP_DEN       = 64'sd16000000;
    localparam longint       ENG_MAX        = 64'sd2147483647;
    localparam longint       ENG_MIN        = -64'sd2147483648;

    typedef struct packed {
        logic [7:0]        high_byte;
        logic [7:0]        low_byte;
        logic [TEMP_W-1:0] temperature;
    } probe_reading_t;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [Q16_W-1:0]  eng;
        logic              sat;
    } calib_result_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [7:0]           raw_high_byte = '0;
    logic [7:0]           raw_low_byte  = '0;
    logic [TEMP_W-1:0]    temperature   = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [RAW_W-1:0]     raw_value;
    logic [Q16_W-1:0]     eng_value;
    logic                 saturated;

    // Register copies used by the predictor.
    longint               calib_q = 400;
    longint               coef_q  = 0;
    longint               gain_q  = 65536;
    longint               bias_q  = 0;

    probe_reading_t       pending_readings[$];
    calib_result_t        expected_results[$];
    probe_reading_t       next_reading;
    calib_result_t        want;

    int                   readings_queued = 0;
    int                   results_seen    = 0;
    int                   saturated_seen  = 0;
    int                   settings_count  = 1;
    int                   mismatch_count  = 0;
    int                   idle_cycles     = 0;
    int                   send_gap        = 0;
    int                   recv_hold       = 0;
    bit                   send_quiet      = 1'b0;
    bit                   recv_quiet      = 1'b0;

    analog_probe_calibrated_reading_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_high_byte (raw_high_byte),
        .raw_low_byte  (raw_low_byte),
        .temperature   (temperature),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .raw_value     (raw_value),
        .eng_value     (eng_value),
        .saturated     (saturated)
    );

    always #5 clk = ~clk;

    function automatic calib_result_t calibrate(input probe_reading_t rd);
        calib_result_t res;
        logic [7:0]    hb;
        logic [3:0]    lb;
        longint        raw_q;
        longint        temp_q;
        longint        factor;
        longint        num;
        longint        comp;
        longint        eng;
        hb = ~rd.high_byte;
        lb = ~rd.low_byte[3:0];
        for (int i = 0; i < 8; i++)
            res.raw[11-i] = hb[i];
        for (int i = 0; i < 4; i++)
            res.raw[3-i] = lb[i];
        raw_q  = res.raw;
        temp_q = $signed(rd.temperature);
        factor = COMP_DEN + (temp_q - calib_q) * coef_q;
        num    = raw_q * factor * 65536;
        comp   = num / COMP_DEN;
        if (num % COMP_DEN != 0 && num < 0)
            comp = comp - 1;
        // The gain is split so that no product overflows 64 bits.
        eng = comp * (gain_q >>> 16) + ((comp * (gain_q & 65535)) >>> 16) + bias_q;
        res.sat = 1'b0;
        if (eng > ENG_MAX)
        begin
            eng     = ENG_MAX;
            res.sat = 1'b1;
        end
        else if (eng < ENG_MIN)
        begin
            eng     = ENG_MIN;
            res.sat = 1'b1;
        end
        res.eng = eng[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CALIB_TEMPERATURE: calib_q = $signed(data[TEMP_W-1:0]);
            REG_TEMP_COEFFICIENT:  coef_q  = data[COEF_W-1:0];
            REG_GAIN:              gain_q  = $signed(data);
            REG_BIAS:              bias_q  = $signed(data);
            default: ;
        endcase
    endtask

    function automatic void queue_reading(input logic [7:0] hi, input logic [7:0] lo,
                                          input logic [TEMP_W-1:0] temp);
        pending_readings.push_back('{hi, lo, temp});
        readings_queued++;
    endfunction

    task automatic wait_for_results();
        do @(posedge clk); while (results_seen != readings_queued);
    endtask

    task automatic write_settings(input int cal, input int coef, input int g, input int b);
        apb_write(REG_CALIB_TEMPERATURE, cal);
        apb_write(REG_TEMP_COEFFICIENT, coef);
        apb_write(REG_GAIN, g);
        apb_write(REG_BIAS, b);
        settings_count++;
    endtask

    task automatic randomize_settings();
        int cal;
        int coef;
        int g;
        int b;
        bit realistic;
        realistic = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       cal = -880;
            1:       cal = 2000;
            2:       cal = int'($urandom_range(0, 4095)) - 2048;
            default: cal = int'($urandom_range(0, 2880)) - 880;
        endcase
        if (realistic)
        begin
            coef = $urandom_range(0, 300);
            g    = int'($urandom_range(0, 524288)) - 262144;
            b    = int'($urandom) >>> 2;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       coef = 65535;
                1:       coef = 0;
                default: coef = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       g = 32'h7FFF_FFFF;
                1:       g = 32'h8000_0000;
                2:       g = 0;
                3:       g = 65536;
                default: g = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       b = 32'h7FFF_FFFF;
                1:       b = 32'h8000_0000;
                2:       b = 0;
                default: b = $urandom;
            endcase
        end
        write_settings(cal, coef, g, b);
    endtask

    // Input driver: one transfer per queued reading, with a random gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            raw_high_byte <= '0;
            raw_low_byte  <= '0;
            temperature   <= '0;
            send_gap      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(
                    calibrate(probe_reading_t'({raw_high_byte, raw_low_byte, temperature})));
                idle_cycles = 0;
            end
            if (in_valid && in_stall)
            begin
                // The payload holds until the transfer completes.
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_readings.size() != 0)
            begin
                next_reading  = pending_readings.pop_front();
                raw_high_byte <= next_reading.high_byte;
                raw_low_byte  <= next_reading.low_byte;
                temperature   <= next_reading.temperature;
                in_valid      <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 15);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result transfer and stalls at random after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                idle_cycles = 0;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result raw %0d eng %0d sat %0b",
                                              raw_value, $signed(eng_value), saturated));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (raw_value !== want.raw)
                        report_mismatch($sformatf("raw_value %0d, expected %0d",
                                                  raw_value, want.raw));
                    if (eng_value !== want.eng)
                        report_mismatch($sformatf("eng_value %0d, expected %0d (raw %0d)",
                                                  $signed(eng_value), $signed(want.eng),
                                                  want.raw));
                    if (saturated !== want.sat)
                        report_mismatch($sformatf("saturated %0b, expected %0b (raw %0d)",
                                                  saturated, want.sat, want.raw));
                    if (want.sat)
                        saturated_seen++;
                end
                if ($urandom_range(0, 31) == 0)
                    recv_quiet = !recv_quiet;
                recv_hold = recv_quiet ? 0 : $urandom_range(0, 15);
            end
            else if (recv_hold != 0)
            begin
                recv_hold--;
            end
            out_stall <= (recv_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int temp;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: raw decode extremes, ignored low-byte bits, out-of-range temperatures.
        queue_reading(8'hFF, 8'hFF, 12'd400);
        queue_reading(8'h00, 8'h00, 12'd400);
        queue_reading(8'h00, 8'hF0, 12'd400);
        queue_reading(8'hAA, 8'h5A, 12'h800);
        queue_reading(8'h55, 8'hA5, 12'h7FF);
        queue_reading(8'h01, 8'hFE, 12'd0);
        wait_for_results();

        // Largest gain and bias; a low temperature drives the compensation factor negative.
        write_settings(2000, 65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_reading(8'h00, 8'h00, 12'h800);
        queue_reading(8'h00, 8'h00, 12'h7FF);
        queue_reading(8'hFF, 8'hFF, 12'h800);
        queue_reading(8'hFE, 8'hFF, 12'd2000);
        queue_reading(8'h00, 8'h0F, -12'sd880);
        queue_reading(8'hFF, 8'hFE, 12'd1999);
        wait_for_results();

        // Most negative gain and bias.
        write_settings(-880, 244, 32'h8000_0000, 32'h8000_0000);
        queue_reading(8'hFF, 8'hFF, 12'd2000);
        queue_reading(8'hFF, 8'hFE, 12'd2000);
        queue_reading(8'hFF, 8'h7E, -12'sd881);
        queue_reading(8'h7F, 8'hFF, 12'd2001);
        queue_reading(8'h00, 8'h00, 12'h800);
        queue_reading(8'h00, 8'h00, 12'h7FF);
        wait_for_results();

        write_settings(-2048, 1, 0, -1);
        queue_reading(8'h00, 8'h00, 12'h7FF);
        queue_reading(8'h3C, 8'hC3, 12'h800);
        queue_reading(8'hC3, 8'h3C, 12'h123);
        queue_reading(8'h0F, 8'h96, 12'hFFF);
        wait_for_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_settings();
            for (int n = 0; n < PHASE_READINGS; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    temp = $urandom_range(0, 4095);
                else
                    temp = int'($urandom_range(0, 2880)) - 880;
                queue_reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              12'(temp));
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Checked %0d probe readings under %0d register settings, %0d of them clipped.",
                 results_seen, settings_count, saturated_seen);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
